/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the keypad reader.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/alkd_pkg.sv */
// ---------------------------------------------------------------------------
// alkd_pkg
// Widths, constants, codes and types shared by the keypad reader modules.
// ---------------------------------------------------------------------------
package alkd_pkg;

  localparam int SAMPLE_SLOTS = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int COUNT_BITS   = 7;
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(SAMPLE_SLOTS);
  localparam int DIV_BITS     = $clog2(SAMPLE_SLOTS + 1);
  localparam int STEP_BITS    = $clog2(SUM_BITS);
  localparam int CORR_BITS    = SAMPLE_BITS + 2;
  localparam int KEY_BITS     = 4;
  localparam int RUN_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [KEY_BITS-1:0]    keys_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam sample_t CAL_STANDARD = sample_t'(12'h800);
  localparam sample_t CAL_OFFSET   = sample_t'(12'h028);
  localparam sample_t LEVEL_MAX    = '1;

  localparam sample_t CAL_RESET    = sample_t'(12'h800);
  localparam sample_t UP_RESET     = sample_t'(736);
  localparam sample_t DOWN_RESET   = sample_t'(1309);
  localparam sample_t LEFT_RESET   = sample_t'(1932);
  localparam sample_t RIGHT_RESET  = sample_t'(2702);
  localparam logic [RUN_BITS-1:0] STABLE_RESET = RUN_BITS'(3);

  localparam logic [CFG_INDEX_BITS-1:0] REG_CAL    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOTIFY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOWN   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;

  localparam keys_t KEY_NONE  = 4'b0000;
  localparam keys_t KEY_UP    = 4'b0001;
  localparam keys_t KEY_DOWN  = 4'b0010;
  localparam keys_t KEY_LEFT  = 4'b0100;
  localparam keys_t KEY_RIGHT = 4'b1000;

endpackage

/* design/adc_ladder_keypad_debounce.sv */
// ---------------------------------------------------------------------------
// adc_ladder_keypad_debounce
// Resistor-ladder keypad reader: averages one ADC conversion, corrects the
// offset, classifies the level into a key and debounces the key set.
// ---------------------------------------------------------------------------
// For a good conversion the accepting edge loads the sample lanes, then the
// merge stage registers the total, the start state launches the divider, the
// bit-serial divider divides the total by the sample count, the finish state
// passes the divider's done flag, and the last edge corrects, classifies and
// debounces, loading the result once the output register is free. A timeout
// or a bad count goes from idle straight to the finish state. Only one request
// is worked on at a time, so a request holds the input until its result is
// loaded, and the next request is taken while a finished result still waits
// in the output register.
module adc_ladder_keypad_debounce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [alkd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [alkd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                timed_out,
  input  logic [alkd_pkg::COUNT_BITS-1:0]     fifo_count,
  input  alkd_pkg::sample_t                   sample_0,
  input  alkd_pkg::sample_t                   sample_1,
  input  alkd_pkg::sample_t                   sample_2,
  input  alkd_pkg::sample_t                   sample_3,
  input  alkd_pkg::sample_t                   sample_4,
  input  alkd_pkg::sample_t                   sample_5,
  input  alkd_pkg::sample_t                   sample_6,
  input  alkd_pkg::sample_t                   sample_7,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output alkd_pkg::sample_t                   level,
  output alkd_pkg::keys_t                     detected_keys,
  output alkd_pkg::keys_t                     committed_keys,
  output logic                                changed
);

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  alkd_pkg::sample_t                      calibration_word;
  logic                                   notify_enabled;
  alkd_pkg::sample_t                      up_ceiling;
  alkd_pkg::sample_t                      down_ceiling;
  alkd_pkg::sample_t                      left_ceiling;
  alkd_pkg::sample_t                      right_ceiling;
  logic [alkd_pkg::RUN_BITS-1:0]          stable_needed;

  alkd_pkg::keys_t                        candidate_keys;
  alkd_pkg::keys_t                        candidate_keys_next;
  logic [alkd_pkg::RUN_BITS-1:0]          stable_run;
  logic [alkd_pkg::RUN_BITS-1:0]          stable_run_next;
  alkd_pkg::keys_t                        debounced_keys;
  alkd_pkg::keys_t                        debounced_keys_next;
  logic                                   changed_next;

  alkd_pkg::sample_t [alkd_pkg::SAMPLE_SLOTS-1:0] samples;
  alkd_pkg::sample_t [alkd_pkg::SAMPLE_SLOTS-1:0] lanes;
  alkd_pkg::sum_t                         total;
  alkd_pkg::sum_t                         quotient;
  alkd_pkg::div_status_t                  div_stat;
  logic [alkd_pkg::DIV_BITS-1:0]          count;
  logic [1:0]                             item_status;
  logic [1:0]                             status_in;

  logic                                   accept;
  logic                                   out_free;
  logic                                   finish;
  alkd_pkg::sample_t                      avg;
  logic signed [alkd_pkg::CORR_BITS-1:0]  corr;
  alkd_pkg::sample_t                      level_next;
  alkd_pkg::keys_t                        keys_next;

  assign samples = {sample_7, sample_6, sample_5, sample_4,
                    sample_3, sample_2, sample_1, sample_0};

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = state == S_FIN && out_free;

  always_comb begin
    if (timed_out) begin
      status_in = alkd_pkg::ST_TIMEOUT;
    end else if (fifo_count == '0
                 || fifo_count > alkd_pkg::COUNT_BITS'(alkd_pkg::SAMPLE_SLOTS)) begin
      status_in = alkd_pkg::ST_BAD_COUNT;
    end else begin
      status_in = alkd_pkg::ST_OK;
    end
  end

  for (genvar g = 0; g < alkd_pkg::SAMPLE_SLOTS; g++) begin : g_lane
    alkd_lane u_lane (
      .clk        (clk),
      .load       (accept),
      .lane_id    (alkd_pkg::COUNT_BITS'(g)),
      .fifo_count (fifo_count),
      .sample     (samples[g]),
      .value      (lanes[g])
    );
  end

  alkd_merge u_merge (
    .clk   (clk),
    .lanes (lanes),
    .total (total)
  );

  alkd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (total),
    .divisor  (count),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_status <= status_in;
      count       <= fifo_count[alkd_pkg::DIV_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (status_in == alkd_pkg::ST_OK) ? S_SUM : S_FIN;
        end
      end
      S_SUM:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign avg  = quotient[alkd_pkg::SAMPLE_BITS-1:0];
  assign corr = $signed({2'b00, avg}) + $signed({2'b00, alkd_pkg::CAL_STANDARD})
              - $signed({2'b00, calibration_word}) + $signed({2'b00, alkd_pkg::CAL_OFFSET});

  always_comb begin
    level_next = '0;
    keys_next  = alkd_pkg::KEY_NONE;
    if (item_status == alkd_pkg::ST_OK) begin
      if (corr < 0) begin
        level_next = '0;
      end else if (corr > $signed({2'b00, alkd_pkg::LEVEL_MAX})) begin
        level_next = alkd_pkg::LEVEL_MAX;
      end else begin
        level_next = corr[alkd_pkg::SAMPLE_BITS-1:0];
      end
      if (level_next <= up_ceiling) begin
        keys_next = alkd_pkg::KEY_UP;
      end else if (level_next <= down_ceiling) begin
        keys_next = alkd_pkg::KEY_DOWN;
      end else if (level_next <= left_ceiling) begin
        keys_next = alkd_pkg::KEY_LEFT;
      end else if (level_next <= right_ceiling) begin
        keys_next = alkd_pkg::KEY_RIGHT;
      end
    end
  end

  always_comb begin
    candidate_keys_next = candidate_keys;
    stable_run_next     = stable_run;
    debounced_keys_next = debounced_keys;
    changed_next        = 1'b0;
    if (!notify_enabled) begin
      candidate_keys_next = debounced_keys;
      stable_run_next     = '0;
    end else if (item_status == alkd_pkg::ST_OK) begin
      if (keys_next == candidate_keys) begin
        if (stable_run < stable_needed) begin
          stable_run_next = stable_run + 1'b1;
        end
      end else begin
        candidate_keys_next = keys_next;
        stable_run_next     = alkd_pkg::RUN_BITS'(1);
      end
      if (stable_run_next >= stable_needed && candidate_keys_next != debounced_keys) begin
        debounced_keys_next = candidate_keys_next;
        changed_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      candidate_keys   <= '0;
      stable_run       <= '0;
      debounced_keys   <= '0;
      calibration_word <= alkd_pkg::CAL_RESET;
      notify_enabled   <= 1'b0;
      up_ceiling       <= alkd_pkg::UP_RESET;
      down_ceiling     <= alkd_pkg::DOWN_RESET;
      left_ceiling     <= alkd_pkg::LEFT_RESET;
      right_ceiling    <= alkd_pkg::RIGHT_RESET;
      stable_needed    <= alkd_pkg::STABLE_RESET;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid      <= 1'b1;
        candidate_keys <= candidate_keys_next;
        stable_run     <= stable_run_next;
        debounced_keys <= debounced_keys_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          alkd_pkg::REG_CAL:    calibration_word <= cfg_data[alkd_pkg::SAMPLE_BITS-1:0];
          alkd_pkg::REG_NOTIFY: notify_enabled   <= cfg_data[0];
          alkd_pkg::REG_UP:     up_ceiling       <= cfg_data[alkd_pkg::SAMPLE_BITS-1:0];
          alkd_pkg::REG_DOWN:   down_ceiling     <= cfg_data[alkd_pkg::SAMPLE_BITS-1:0];
          alkd_pkg::REG_LEFT:   left_ceiling     <= cfg_data[alkd_pkg::SAMPLE_BITS-1:0];
          alkd_pkg::REG_RIGHT:  right_ceiling    <= cfg_data[alkd_pkg::SAMPLE_BITS-1:0];
          alkd_pkg::REG_STABLE: stable_needed    <= cfg_data[alkd_pkg::RUN_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status         <= item_status;
      level          <= level_next;
      detected_keys  <= keys_next;
      committed_keys <= debounced_keys_next;
      changed        <= changed_next;
    end
  end

  `ASSERT_SAME(a_error_clears_level, clk, rst,
    out_valid && status != alkd_pkg::ST_OK,
    level == '0 && detected_keys == alkd_pkg::KEY_NONE && !changed)
  `ASSERT_SAME(a_keys_onehot, clk, rst, out_valid, $onehot0(detected_keys))
  `ASSERT_NEXT(a_change_commits, clk, rst, finish && changed_next,
    out_valid && committed_keys == candidate_keys && status == alkd_pkg::ST_OK)

endmodule

/* design/alkd_lane.sv */
// ---------------------------------------------------------------------------
// alkd_lane
// One sample lane: captures its sample when the request is taken and
// zeroes it when the slot lies beyond the reported FIFO count.
// ---------------------------------------------------------------------------
module alkd_lane (
  input  logic                               clk,
  input  logic                               load,
  input  logic [alkd_pkg::COUNT_BITS-1:0]    lane_id,
  input  logic [alkd_pkg::COUNT_BITS-1:0]    fifo_count,
  input  alkd_pkg::sample_t                  sample,
  output alkd_pkg::sample_t                  value
);

  always_ff @(posedge clk) begin
    if (load) begin
      value <= (lane_id < fifo_count) ? sample : '0;
    end
  end

endmodule

/* design/alkd_merge.sv */
// ---------------------------------------------------------------------------
// alkd_merge
// Merging stage: adds the masked lane values into one registered total.
// ---------------------------------------------------------------------------
module alkd_merge (
  input  logic                                    clk,
  input  alkd_pkg::sample_t [alkd_pkg::SAMPLE_SLOTS-1:0] lanes,
  output alkd_pkg::sum_t                          total
);

  alkd_pkg::sum_t acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < alkd_pkg::SAMPLE_SLOTS; i++) begin
      acc = acc + alkd_pkg::sum_t'(lanes[i]);
    end
  end

  always_ff @(posedge clk) begin
    total <= acc;
  end

endmodule

/* design/alkd_div.sv */
// ---------------------------------------------------------------------------
// alkd_div
// Restoring divider: one quotient bit per cycle, total divided by the
// sample count.
// ---------------------------------------------------------------------------
module alkd_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  alkd_pkg::sum_t                     dividend,
  input  logic [alkd_pkg::DIV_BITS-1:0]      divisor,
  output alkd_pkg::sum_t                     quotient,
  output alkd_pkg::div_status_t              stat
);

  logic [alkd_pkg::DIV_BITS-1:0]  rem;
  logic [alkd_pkg::DIV_BITS:0]    trial;
  logic [alkd_pkg::STEP_BITS-1:0] step;
  logic                           fits;

  assign trial = {rem, quotient[alkd_pkg::SUM_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && step == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      step     <= alkd_pkg::STEP_BITS'(alkd_pkg::SUM_BITS - 1);
    end else if (stat.busy) begin
      if (fits) begin
        rem <= alkd_pkg::DIV_BITS'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[alkd_pkg::DIV_BITS-1:0];
      end
      quotient <= {quotient[alkd_pkg::SUM_BITS-2:0], fits};
      step     <= step - 1'b1;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad reader testbench
// Drives ADC conversion requests into the resistor-ladder keypad reader and
// predicts each result in step with the debounce state. Covers error items,
// key boundaries, register sweeps, random bursts, idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 25;

  typedef struct {
    logic                                            timed_out;
    logic [alkd_pkg::COUNT_BITS-1:0]                 count;
    alkd_pkg::sample_t [alkd_pkg::SAMPLE_SLOTS-1:0]  samples;
  } reading_t;

  typedef struct {
    logic [1:0]        status;
    alkd_pkg::sample_t level;
    alkd_pkg::keys_t   detected;
    alkd_pkg::keys_t   committed;
    logic              changed;
  } key_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [alkd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [alkd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic timed_out = 1'b0;
  logic [alkd_pkg::COUNT_BITS-1:0] fifo_count = '0;
  alkd_pkg::sample_t sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
  alkd_pkg::sample_t sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  alkd_pkg::sample_t level;
  alkd_pkg::keys_t detected_keys;
  alkd_pkg::keys_t committed_keys;
  logic changed;

  // Shadow registers and debounce state of the predictor.
  alkd_pkg::sample_t cal_word = alkd_pkg::CAL_RESET;
  logic notify_on = 1'b0;
  alkd_pkg::sample_t ceiling_up = alkd_pkg::UP_RESET;
  alkd_pkg::sample_t ceiling_down = alkd_pkg::DOWN_RESET;
  alkd_pkg::sample_t ceiling_left = alkd_pkg::LEFT_RESET;
  alkd_pkg::sample_t ceiling_right = alkd_pkg::RIGHT_RESET;
  logic [alkd_pkg::RUN_BITS-1:0] run_needed = alkd_pkg::STABLE_RESET;
  alkd_pkg::keys_t candidate = alkd_pkg::KEY_NONE;
  logic [alkd_pkg::RUN_BITS-1:0] run_length = '0;
  alkd_pkg::keys_t committed = alkd_pkg::KEY_NONE;

  key_result_t awaited_results[$];

  int tx_idle_pct = 33;
  int rx_idle_pct = 33;
  int hold_off_requests = 0;
  int hold_off_served = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int readings_sent = 0;
  int timeouts_sent = 0;
  int bad_counts_sent = 0;
  int commits_seen = 0;
  int settings_applied = 0;

  adc_ladder_keypad_debounce dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .timed_out(timed_out), .fifo_count(fifo_count),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
    .sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .level(level), .detected_keys(detected_keys),
    .committed_keys(committed_keys), .changed(changed)
  );

  always #2 clk = ~clk;

  function automatic key_result_t average_classify_debounce(input reading_t r);
    key_result_t res;
    int total;
    int lvl;
    res.status = alkd_pkg::ST_OK;
    res.level = '0;
    res.detected = alkd_pkg::KEY_NONE;
    res.changed = 1'b0;
    if (r.timed_out) begin
      res.status = alkd_pkg::ST_TIMEOUT;
    end else if (r.count == 0 || r.count > alkd_pkg::SAMPLE_SLOTS) begin
      res.status = alkd_pkg::ST_BAD_COUNT;
    end else begin
      total = 0;
      for (int i = 0; i < r.count; i++) total += int'(r.samples[i]);
      lvl = total / int'(r.count) + int'(alkd_pkg::CAL_STANDARD) - int'(cal_word)
            + int'(alkd_pkg::CAL_OFFSET);
      if (lvl < 0) lvl = 0;
      if (lvl > int'(alkd_pkg::LEVEL_MAX)) lvl = int'(alkd_pkg::LEVEL_MAX);
      res.level = alkd_pkg::sample_t'(lvl);
      if (res.level <= ceiling_up) res.detected = alkd_pkg::KEY_UP;
      else if (res.level <= ceiling_down) res.detected = alkd_pkg::KEY_DOWN;
      else if (res.level <= ceiling_left) res.detected = alkd_pkg::KEY_LEFT;
      else if (res.level <= ceiling_right) res.detected = alkd_pkg::KEY_RIGHT;
    end
    if (!notify_on) begin
      candidate = committed;
      run_length = '0;
    end else if (res.status == alkd_pkg::ST_OK) begin
      if (res.detected == candidate) begin
        if (run_length < run_needed) run_length++;
      end else begin
        candidate = res.detected;
        run_length = 1;
      end
      if (run_length >= run_needed && candidate != committed) begin
        committed = candidate;
        res.changed = 1'b1;
      end
    end
    res.committed = committed;
    return res;
  endfunction

  function automatic reading_t make_reading(input logic tmo, input int count, input int avg,
                                            input int spread);
    reading_t r;
    int s;
    r.timed_out = tmo;
    r.count = alkd_pkg::COUNT_BITS'(count);
    for (int i = 0; i < alkd_pkg::SAMPLE_SLOTS; i++) begin
      if (i < count) begin
        s = avg + int'($urandom_range(2 * spread)) - spread;
        if (s < 0) s = 0;
        if (s > int'(alkd_pkg::LEVEL_MAX)) s = int'(alkd_pkg::LEVEL_MAX);
        r.samples[i] = alkd_pkg::sample_t'(s);
      end else begin
        r.samples[i] = alkd_pkg::sample_t'($urandom_range(int'(alkd_pkg::LEVEL_MAX)));
      end
    end
    return r;
  endfunction

  function automatic int avg_for_level(input int lvl);
    return lvl - int'(alkd_pkg::CAL_STANDARD) + int'(cal_word) - int'(alkd_pkg::CAL_OFFSET);
  endfunction

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  task automatic send_reading(input reading_t r);
    key_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    timed_out <= r.timed_out;
    fifo_count <= r.count;
    sample_0 <= r.samples[0];
    sample_1 <= r.samples[1];
    sample_2 <= r.samples[2];
    sample_3 <= r.samples[3];
    sample_4 <= r.samples[4];
    sample_5 <= r.samples[5];
    sample_6 <= r.samples[6];
    sample_7 <= r.samples[7];
    do @(posedge clk); while (!in_ready);
    res = average_classify_debounce(r);
    awaited_results.push_back(res);
    readings_sent++;
    if (res.status == alkd_pkg::ST_TIMEOUT) timeouts_sent++;
    if (res.status == alkd_pkg::ST_BAD_COUNT) bad_counts_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [alkd_pkg::CFG_INDEX_BITS-1:0] index,
                                input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= alkd_pkg::CFG_DATA_BITS'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      alkd_pkg::REG_CAL:    cal_word = alkd_pkg::sample_t'(value);
      alkd_pkg::REG_NOTIFY: notify_on = value[0];
      alkd_pkg::REG_UP:     ceiling_up = alkd_pkg::sample_t'(value);
      alkd_pkg::REG_DOWN:   ceiling_down = alkd_pkg::sample_t'(value);
      alkd_pkg::REG_LEFT:   ceiling_left = alkd_pkg::sample_t'(value);
      alkd_pkg::REG_RIGHT:  ceiling_right = alkd_pkg::sample_t'(value);
      alkd_pkg::REG_STABLE: run_needed = alkd_pkg::RUN_BITS'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int cal, input int notify, input int up, input int down,
                               input int left, input int right, input int stable);
    write_register(alkd_pkg::REG_CAL, cal);
    write_register(alkd_pkg::REG_NOTIFY, notify);
    write_register(alkd_pkg::REG_UP, up);
    write_register(alkd_pkg::REG_DOWN, down);
    write_register(alkd_pkg::REG_LEFT, left);
    write_register(alkd_pkg::REG_RIGHT, right);
    write_register(alkd_pkg::REG_STABLE, stable);
    settings_applied++;
  endtask

  task automatic send_random_traffic(input int n);
    int sent;
    int pick;
    int burst;
    int base;
    int spread;
    int cnt;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_reading(make_reading(1'b1, $urandom_range(127), $urandom_range(4095), 4095));
        sent++;
      end else if (pick < 15) begin
        cnt = $urandom_range(1) ? 0 : $urandom_range(127, alkd_pkg::SAMPLE_SLOTS + 1);
        send_reading(make_reading(1'b0, cnt, $urandom_range(4095), 4095));
        sent++;
      end else if (pick < 30) begin
        send_reading(make_reading(1'b0, $urandom_range(alkd_pkg::SAMPLE_SLOTS, 1),
                                  $urandom_range(4095), 4095));
        sent++;
      end else begin
        burst = $urandom_range(8, 1);
        base = $urandom_range(4095);
        spread = $urandom_range(4);
        repeat (burst) begin
          send_reading(make_reading(1'b0, $urandom_range(alkd_pkg::SAMPLE_SLOTS, 1),
                                    base, spread));
        end
        sent += burst;
      end
    end
  endtask

  task automatic test_error_items();
    send_reading(make_reading(1'b1, 0, 0, 0));
    send_reading(make_reading(1'b1, 127, 4095, 0));
    send_reading(make_reading(1'b0, 0, 100, 0));
    send_reading(make_reading(1'b0, alkd_pkg::SAMPLE_SLOTS + 1, 100, 0));
    send_reading(make_reading(1'b0, 127, 100, 0));
    send_reading(make_reading(1'b0, 1, 0, 0));
    send_reading(make_reading(1'b0, alkd_pkg::SAMPLE_SLOTS, 4095, 0));
    send_reading(make_reading(1'b0, alkd_pkg::SAMPLE_SLOTS, 0, 0));
    send_reading(make_reading(1'b0, 5, 2000, 3));
    settle();
  endtask

  task automatic test_key_commits();
    int key_levels[5];
    write_register(alkd_pkg::REG_NOTIFY, 1);
    // Each key is hit exactly at its ceiling; one past the right ceiling is no key.
    key_levels = '{int'(ceiling_up), int'(ceiling_down), int'(ceiling_left),
                   int'(ceiling_right), int'(ceiling_right) + 1};
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (k == 2 && j == 2) send_reading(make_reading(1'b1, 3, key_levels[k], 0));
        send_reading(make_reading(1'b0, 1 + (k + j) % alkd_pkg::SAMPLE_SLOTS,
                                  avg_for_level(key_levels[k]), 0));
      end
    end
    settle();
  endtask

  task automatic test_settings_sweep();
    int lvl;
    apply_setting(0, 1, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET, alkd_pkg::LEFT_RESET,
                  alkd_pkg::RIGHT_RESET, 1);
    send_random_traffic(35);
    settle();
    apply_setting(4095, 1, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET, alkd_pkg::LEFT_RESET,
                  alkd_pkg::RIGHT_RESET, 7);
    send_random_traffic(35);
    settle();
    apply_setting(alkd_pkg::CAL_RESET, 1, 0, 0, 0, 0, 2);
    send_random_traffic(35);
    settle();
    apply_setting(alkd_pkg::CAL_RESET, 1, 4095, 4095, 4095, 4095, 1);
    send_random_traffic(35);
    settle();
    // Ceilings out of order: the down key can never win.
    apply_setting(1800, 1, 3000, 1000, 2000, 3500, 4);
    send_random_traffic(35);
    settle();
    apply_setting(alkd_pkg::CAL_RESET, 0, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET,
                  alkd_pkg::LEFT_RESET, alkd_pkg::RIGHT_RESET, 3);
    send_random_traffic(35);
    settle();
    apply_setting(2100, 1, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET, alkd_pkg::LEFT_RESET,
                  alkd_pkg::RIGHT_RESET, 0);
    send_random_traffic(35);
    settle();
    // A run longer than a newly lowered requirement still commits.
    apply_setting(alkd_pkg::CAL_RESET, 1, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET,
                  alkd_pkg::LEFT_RESET, alkd_pkg::RIGHT_RESET, 7);
    lvl = (committed != alkd_pkg::KEY_UP) ? int'(ceiling_up) - 100 : int'(ceiling_down) - 100;
    repeat (5) send_reading(make_reading(1'b0, 4, avg_for_level(lvl), 2));
    settle();
    write_register(alkd_pkg::REG_STABLE, 2);
    send_reading(make_reading(1'b0, 2, avg_for_level(lvl), 2));
    settle();
    apply_setting(alkd_pkg::CAL_RESET, 1, alkd_pkg::UP_RESET, alkd_pkg::DOWN_RESET,
                  alkd_pkg::LEFT_RESET, alkd_pkg::RIGHT_RESET, alkd_pkg::STABLE_RESET);
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
    send_random_traffic(500);
    settle();
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_traffic(120);
    settle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_requests++;
    send_random_traffic(25);
    settle();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_requests != hold_off_served) begin
        hold_off_served++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d level %0d keys %0d",
                 $time, status, level, detected_keys);
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", want.status, status);
        compare_field("level", want.level, level);
        compare_field("detected_keys", want.detected, detected_keys);
        compare_field("committed_keys", want.committed, committed_keys);
        compare_field("changed", want.changed, changed);
        if (changed) commits_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("** adc_ladder_keypad_debounce: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_error_items();
    test_key_commits();
    test_settings_sweep();
    test_random_traffic();
    test_no_idle();
    test_backpressure();
    $display("Run covered %0d readings (%0d timed out, %0d with a bad count) over %0d settings,",
             readings_sent, timeouts_sent, bad_counts_sent, settings_applied);
    $display("with %0d key-set commits, random idling and one long output hold-off.",
             commits_seen);
    if (mismatches == 0) begin
      $display("** adc_ladder_keypad_debounce: PASSED **");
    end else begin
      $display("** adc_ladder_keypad_debounce: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/alkd_pkg.sv
design/alkd_lane.sv
design/alkd_merge.sv
design/alkd_div.sv
design/adc_ladder_keypad_debounce.sv
tb/sv/testbench.sv
